// ===== rtl/core/mta_pkg.sv =====
// ----------------------------------------------------------------------------
// mta_pkg
// Shared types and constants of the motion tamper alarm.
// ----------------------------------------------------------------------------
`default_nettype none

package mta_pkg;

  localparam int NUM_AXES = 3;

  localparam int SAMPLE_W = 16;
  localparam int ABS_W    = 17;
  localparam int SUM_W    = 17;
  localparam int REF_W    = 18;
  localparam int TIME_W   = 32;
  localparam int CODE_W   = 16;
  localparam int CFG_W    = 32;
  localparam int IDX_W    = 3;

  localparam int BIT_FAULT = 15;
  localparam int BIT_TILT  = 14;
  localparam int BIT_VIB   = 13;

  typedef enum logic [IDX_W-1:0] {
    REG_TILT_TOL    = 3'd0,
    REG_VIB_TOL     = 3'd1,
    REG_CALIB_MS    = 3'd2,
    REG_SIREN_LEVEL = 3'd3,
    REG_ALERT_LEVEL = 3'd4,
    REG_SIREN_DUR   = 3'd5,
    REG_SIREN_GAP   = 3'd6,
    REG_ALERT_GAP   = 3'd7
  } reg_index_t;

  localparam logic [15:0] RST_TILT_TOL    = 16'd983;
  localparam logic [17:0] RST_VIB_TOL     = 18'd42;
  localparam logic [15:0] RST_CALIB_MS    = 16'd200;
  localparam logic [15:0] RST_SIREN_LEVEL = 16'd1024;
  localparam logic [15:0] RST_ALERT_LEVEL = 16'd32;
  localparam logic [15:0] RST_SIREN_DUR   = 16'd10;
  localparam logic [15:0] RST_SIREN_GAP   = 16'd5;
  localparam logic [31:0] RST_ALERT_GAP   = 32'd60000;

  typedef struct packed {
    logic seed;
    logic widen;
  } lane_ctl_t;

  typedef struct packed {
    logic [CODE_W-1:0] siren_level;
    logic [CODE_W-1:0] alert_level;
    logic [15:0]       siren_duration_ms;
    logic [15:0]       siren_gap_ms;
    logic [TIME_W-1:0] alert_gap_ms;
  } alarm_cfg_t;

  typedef struct packed {
    logic siren_on;
    logic siren_trigger;
    logic alert_send;
  } alarm_out_t;

endpackage

`default_nettype wire

// ===== rtl/core/mta_axis_lane.sv =====
// ----------------------------------------------------------------------------
// mta_axis_lane
// One axis: gyro min/max window with tilt check, accel magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module mta_axis_lane
  import mta_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire lane_ctl_t                  ctl,
  input  wire logic signed [SAMPLE_W-1:0] gyro,
  input  wire logic signed [SAMPLE_W-1:0] accel,
  input  wire logic        [15:0]         tilt_tolerance,
  output logic                            tilt,
  output logic             [ABS_W-1:0]    accel_abs
);

  logic signed [SAMPLE_W-1:0] axis_min;
  logic signed [SAMPLE_W-1:0] axis_max;
  logic signed [17:0]         gyro_ext;
  logic signed [17:0]         bound_hi;
  logic signed [17:0]         bound_lo;
  logic signed [ABS_W-1:0]    accel_ext;

  always_comb begin
    gyro_ext  = {{2{gyro[SAMPLE_W-1]}}, gyro};
    bound_hi  = {{2{axis_max[SAMPLE_W-1]}}, axis_max} + {2'b00, tilt_tolerance};
    bound_lo  = {{2{axis_min[SAMPLE_W-1]}}, axis_min} - {2'b00, tilt_tolerance};
    tilt      = (gyro_ext > bound_hi) || (gyro_ext < bound_lo);
    accel_ext = {accel[SAMPLE_W-1], accel};
    accel_abs = accel_ext[ABS_W-1] ? ABS_W'(-accel_ext) : ABS_W'(accel_ext);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_min <= '0;
      axis_max <= '0;
    end else if (ctl.seed) begin
      axis_min <= gyro;
      axis_max <= gyro;
    end else if (ctl.widen) begin
      if (gyro < axis_min) axis_min <= gyro;
      if (gyro > axis_max) axis_max <= gyro;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mta_alarm.sv =====
// ----------------------------------------------------------------------------
// mta_alarm
// Rate-limited siren and remote alert triggers driven by the error code.
// ----------------------------------------------------------------------------
`default_nettype none

module mta_alarm
  import mta_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              commit,
  input  wire logic              running,
  input  wire logic [CODE_W-1:0] code,
  input  wire logic [TIME_W-1:0] now_ms,
  input  wire alarm_cfg_t        cfg,
  output alarm_out_t             result
);

  logic [TIME_W-1:0] siren_start;
  logic [TIME_W-1:0] alert_start;
  logic              siren_active;
  logic [TIME_W-1:0] siren_elapsed;
  logic [TIME_W-1:0] alert_elapsed;
  logic              siren_fire;
  logic              alert_fire;
  logic              siren_active_next;

  always_comb begin
    siren_elapsed = now_ms - siren_start;
    alert_elapsed = now_ms - alert_start;
    siren_fire    = (code >= cfg.siren_level) &&
                    (siren_elapsed > {16'd0, cfg.siren_gap_ms});
    alert_fire    = (code >= cfg.alert_level) && (alert_elapsed > cfg.alert_gap_ms);
    siren_active_next = siren_active;
    if (siren_elapsed > {16'd0, cfg.siren_duration_ms}) siren_active_next = 1'b0;
    if (siren_fire) siren_active_next = 1'b1;
    result.siren_on      = running ? siren_active_next : siren_active;
    result.siren_trigger = running && siren_fire;
    result.alert_send    = running && alert_fire;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      siren_start  <= '0;
      alert_start  <= '0;
      siren_active <= 1'b0;
    end else if (commit && running) begin
      siren_active <= siren_active_next;
      if (siren_fire) siren_start <= now_ms;
      if (alert_fire) alert_start <= now_ms;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/motion_tamper_alarm.sv =====
// ----------------------------------------------------------------------------
// motion_tamper_alarm
// Tamper alarm on raw gyro/accel samples: calibration, tilt and vibration
// checks, rate-limited siren and alert.
//
//   channel   signals                          direction
//   in        in_valid/in_ready, sample fields  sink
//   out       out_valid/out_ready, result       source
//   cfg       cfg_write, cfg_index, cfg_data    sink, write only
//
// One sample per cycle unless the output stalls; each result is registered
// as its sample is taken. Three axis lanes check tilt and accel magnitude
// in parallel; the code they feed drives the alarm triggers in the same
// cycle. The output register frees when out_ready is high, so a new sample
// is taken in the cycle its predecessor leaves. Reset is synchronous and
// returns to awaiting the first sample with the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module motion_tamper_alarm
  import mta_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic signed [SAMPLE_W-1:0] gyro_x,
  input  wire logic signed [SAMPLE_W-1:0] gyro_y,
  input  wire logic signed [SAMPLE_W-1:0] gyro_z,
  input  wire logic signed [SAMPLE_W-1:0] accel_x,
  input  wire logic signed [SAMPLE_W-1:0] accel_y,
  input  wire logic signed [SAMPLE_W-1:0] accel_z,
  input  wire logic                       sensor_fault,
  input  wire logic        [TIME_W-1:0]   now_ms,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic             [CODE_W-1:0]   error_code,
  output logic                            calibrating,
  output logic                            siren_on,
  output logic                            siren_trigger,
  output logic                            alert_send,
  input  wire logic                       cfg_write,
  input  wire logic        [IDX_W-1:0]    cfg_index,
  input  wire logic        [CFG_W-1:0]    cfg_data
);

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_CALIB,
    PH_RUN
  } phase_t;

  phase_t            phase;
  logic [TIME_W-1:0] calib_start;
  logic [REF_W-1:0]  accel_reference;

  logic [15:0]       tilt_tolerance;
  logic [17:0]       vibration_tolerance;
  logic [15:0]       calib_ms;
  alarm_cfg_t        alarm_cfg;

  logic                       in_accept;
  logic                       running;
  logic                       in_window;
  lane_ctl_t                  lane_ctl;
  logic signed [SAMPLE_W-1:0] gyro_vec  [NUM_AXES];
  logic signed [SAMPLE_W-1:0] accel_vec [NUM_AXES];
  logic        [NUM_AXES-1:0] tilt_vec;
  logic        [ABS_W-1:0]    abs_vec   [NUM_AXES];
  logic        [SUM_W-1:0]    accel_sum;
  logic        [REF_W:0]      sum_ext;
  logic        [REF_W:0]      ref_ext;
  logic        [REF_W:0]      vt_ext;
  logic                       vib;
  logic        [CODE_W-1:0]   code;
  alarm_out_t                 alarm;

  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  assign gyro_vec[0]  = gyro_x;
  assign gyro_vec[1]  = gyro_y;
  assign gyro_vec[2]  = gyro_z;
  assign accel_vec[0] = accel_x;
  assign accel_vec[1] = accel_y;
  assign accel_vec[2] = accel_z;

  always_comb begin
    in_window      = (now_ms - calib_start) < {16'd0, calib_ms};
    running        = (phase == PH_RUN) || ((phase == PH_CALIB) && !in_window);
    lane_ctl.seed  = in_accept && (phase == PH_FIRST);
    lane_ctl.widen = in_accept && (phase == PH_CALIB) && in_window;
  end

  for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
    mta_axis_lane u_lane (
      .clk            (clk),
      .rst            (rst),
      .ctl            (lane_ctl),
      .gyro           (gyro_vec[i]),
      .accel          (accel_vec[i]),
      .tilt_tolerance (tilt_tolerance),
      .tilt           (tilt_vec[i]),
      .accel_abs      (abs_vec[i])
    );
  end

  always_comb begin
    accel_sum = abs_vec[0] + abs_vec[1] + abs_vec[2];
    sum_ext   = (REF_W+1)'(accel_sum);
    ref_ext   = {1'b0, accel_reference};
    vt_ext    = {1'b0, vibration_tolerance};
    vib       = (sum_ext > ref_ext + vt_ext) || (ref_ext > sum_ext + vt_ext);
    code            = '0;
    code[BIT_FAULT] = sensor_fault;
    code[BIT_TILT]  = |tilt_vec;
    code[BIT_VIB]   = vib;
  end

  mta_alarm u_alarm (
    .clk     (clk),
    .rst     (rst),
    .commit  (in_accept),
    .running (running),
    .code    (code),
    .now_ms  (now_ms),
    .cfg     (alarm_cfg),
    .result  (alarm)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tilt_tolerance                <= RST_TILT_TOL;
      vibration_tolerance           <= RST_VIB_TOL;
      calib_ms                      <= RST_CALIB_MS;
      alarm_cfg.siren_level         <= RST_SIREN_LEVEL;
      alarm_cfg.alert_level         <= RST_ALERT_LEVEL;
      alarm_cfg.siren_duration_ms   <= RST_SIREN_DUR;
      alarm_cfg.siren_gap_ms        <= RST_SIREN_GAP;
      alarm_cfg.alert_gap_ms        <= RST_ALERT_GAP;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_TILT_TOL:    tilt_tolerance              <= cfg_data[15:0];
        REG_VIB_TOL:     vibration_tolerance         <= cfg_data[17:0];
        REG_CALIB_MS:    calib_ms                    <= cfg_data[15:0];
        REG_SIREN_LEVEL: alarm_cfg.siren_level       <= cfg_data[15:0];
        REG_ALERT_LEVEL: alarm_cfg.alert_level       <= cfg_data[15:0];
        REG_SIREN_DUR:   alarm_cfg.siren_duration_ms <= cfg_data[15:0];
        REG_SIREN_GAP:   alarm_cfg.siren_gap_ms      <= cfg_data[15:0];
        REG_ALERT_GAP:   alarm_cfg.alert_gap_ms      <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_FIRST;
      calib_start     <= '0;
      accel_reference <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (in_accept) begin
        out_valid <= 1'b1;
        unique case (phase)
          PH_FIRST: begin
            phase           <= PH_CALIB;
            calib_start     <= now_ms;
            accel_reference <= REF_W'(accel_sum);
          end
          PH_CALIB: begin
            if (running) begin
              phase           <= PH_RUN;
              accel_reference <= REF_W'(accel_sum);
            end
          end
          PH_RUN: begin
            accel_reference <= REF_W'(accel_sum);
          end
          default: ;
        endcase
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      error_code    <= running ? code : '0;
      calibrating   <= !running;
      siren_on      <= alarm.siren_on;
      siren_trigger <= alarm.siren_trigger;
      alert_send    <= alarm.alert_send;
    end
  end

`ifndef SYNTHESIS
  a_calib_no_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && calibrating |-> error_code == '0 && !siren_trigger && !alert_send)
    else $error("code or trigger on a calibrating transaction");

  a_trigger_drives_siren: assert property (@(posedge clk) disable iff (rst)
    out_valid && siren_trigger |-> siren_on)
    else $error("siren trigger without siren on");

  a_first_to_calib: assert property (@(posedge clk) disable iff (rst)
    in_accept && phase == PH_FIRST |=> phase == PH_CALIB && calibrating)
    else $error("first transaction did not start calibration");

  a_run_stays: assert property (@(posedge clk) disable iff (rst)
    phase == PH_RUN |=> phase == PH_RUN)
    else $error("left running phase without reset");
`endif

endmodule

`default_nettype wire

// ===== bench/motion_tamper_alarm_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motion_tamper_alarm_tb
// Self-checking bench for the motion tamper alarm. A queue-fed driver offers
// timestamped samples under random gaps, a monitor takes results under random
// stalls and one long hold-off, and every result is checked against an
// in-bench model of calibration, tilt, vibration, siren and alert timing.
// Directed samples cover calibration, its end, window wrap and the threshold
// edges; random phases then sweep the register settings, extremes included.
// ----------------------------------------------------------------------------
module motion_tamper_alarm_tb;
  import mta_pkg::*;

  typedef enum logic [1:0] {
    ST_FIRST,
    ST_CALIB,
    ST_RUN
  } alarm_phase_t;

  typedef struct packed {
    logic [15:0] gyro_x;
    logic [15:0] gyro_y;
    logic [15:0] gyro_z;
    logic [15:0] accel_x;
    logic [15:0] accel_y;
    logic [15:0] accel_z;
    logic        sensor_fault;
    logic [31:0] now_ms;
  } sample_t;

  typedef struct packed {
    logic [15:0] error_code;
    logic        calibrating;
    logic        siren_on;
    logic        siren_trigger;
    logic        alert_send;
  } alarm_result_t;

  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 75;
  localparam int MAX_WAIT      = 18;
  localparam int HOLD_CYCLES   = 240;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] gyro_x, gyro_y, gyro_z;
  logic signed [SAMPLE_W-1:0] accel_x, accel_y, accel_z;
  logic                       sensor_fault;
  logic        [TIME_W-1:0]   now_ms;
  logic                       out_valid;
  logic                       out_ready;
  logic        [CODE_W-1:0]   error_code;
  logic                       calibrating;
  logic                       siren_on;
  logic                       siren_trigger;
  logic                       alert_send;
  logic                       cfg_write;
  logic        [IDX_W-1:0]    cfg_index;
  logic        [CFG_W-1:0]    cfg_data;

  motion_tamper_alarm u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .gyro_x       (gyro_x),
    .gyro_y       (gyro_y),
    .gyro_z       (gyro_z),
    .accel_x      (accel_x),
    .accel_y      (accel_y),
    .accel_z      (accel_z),
    .sensor_fault (sensor_fault),
    .now_ms       (now_ms),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .error_code   (error_code),
    .calibrating  (calibrating),
    .siren_on     (siren_on),
    .siren_trigger(siren_trigger),
    .alert_send   (alert_send),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // register shadows
  logic [15:0] sh_tilt, sh_calib, sh_siren_level, sh_alert_level, sh_siren_dur, sh_siren_gap;
  logic [17:0] sh_vib;
  logic [31:0] sh_alert_gap;

  // alarm model state
  alarm_phase_t st_phase;
  logic [31:0]  st_calib_start, st_siren_start, st_alert_start;
  int           st_min[3], st_max[3];
  int           st_accel_ref;
  logic         st_siren_on;

  sample_t       pending_samples[$];
  alarm_result_t predicted_results[$];
  sample_t       cur_sample;

  logic [31:0] t_now;
  int          last_accel[3];
  bit          tx_calm, rx_calm, hold_armed, hold_done;
  int unsigned tx_wait, rx_wait, rx_hold;
  int          n_fail, n_sent, n_checked, n_calib, n_trig, n_alert, n_tilt, n_vib, n_fault;

  function automatic alarm_result_t predict_alarm(input sample_t s);
    alarm_result_t r;
    int            g[3];
    int            a[3];
    int            sum, tol, vt;
    logic [31:0]   el;
    r = '0;
    g[0] = int'($signed(s.gyro_x));
    g[1] = int'($signed(s.gyro_y));
    g[2] = int'($signed(s.gyro_z));
    a[0] = int'($signed(s.accel_x));
    a[1] = int'($signed(s.accel_y));
    a[2] = int'($signed(s.accel_z));
    sum = 0;
    for (int i = 0; i < 3; i++) sum += (a[i] < 0) ? -a[i] : a[i];
    el = s.now_ms - st_calib_start;
    if (st_phase == ST_FIRST) begin
      st_accel_ref = sum;
      for (int i = 0; i < 3; i++) begin
        st_min[i] = g[i];
        st_max[i] = g[i];
      end
      st_calib_start = s.now_ms;
      st_phase = ST_CALIB;
      r.calibrating = 1'b1;
    end else if (st_phase == ST_CALIB && el < 32'(sh_calib)) begin
      for (int i = 0; i < 3; i++) begin
        if (g[i] < st_min[i]) st_min[i] = g[i];
        if (g[i] > st_max[i]) st_max[i] = g[i];
      end
      r.calibrating = 1'b1;
    end else begin
      tol = int'(sh_tilt);
      vt = int'(sh_vib);
      st_phase = ST_RUN;
      if (s.sensor_fault) r.error_code[BIT_FAULT] = 1'b1;
      for (int i = 0; i < 3; i++) begin
        if (g[i] > st_max[i] + tol || g[i] < st_min[i] - tol) r.error_code[BIT_TILT] = 1'b1;
      end
      if (sum > st_accel_ref + vt || sum < st_accel_ref - vt) r.error_code[BIT_VIB] = 1'b1;
      st_accel_ref = sum;
      if (s.now_ms - st_siren_start > 32'(sh_siren_dur)) st_siren_on = 1'b0;
      if (r.error_code >= sh_siren_level && s.now_ms - st_siren_start > 32'(sh_siren_gap)) begin
        st_siren_start = s.now_ms;
        st_siren_on = 1'b1;
        r.siren_trigger = 1'b1;
      end
      if (r.error_code >= sh_alert_level && s.now_ms - st_alert_start > sh_alert_gap) begin
        st_alert_start = s.now_ms;
        r.alert_send = 1'b1;
      end
    end
    r.siren_on = st_siren_on;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin : drive_samples
    int unsigned w;
    logic        busy;
    if (rst) begin
      in_valid <= 1'b0;
      tx_wait <= 0;
    end else begin
      w = tx_wait;
      busy = in_valid;
      if (in_valid && in_ready) begin
        predicted_results.push_back(predict_alarm(cur_sample));
        n_sent++;
        busy = 1'b0;
        w = tx_calm ? 0 : $urandom_range(0, MAX_WAIT);
      end else if (!in_valid && w != 0) begin
        w = w - 1;
      end
      if (!busy && w == 0 && pending_samples.size() != 0) begin
        cur_sample = pending_samples.pop_front();
        gyro_x <= cur_sample.gyro_x;
        gyro_y <= cur_sample.gyro_y;
        gyro_z <= cur_sample.gyro_z;
        accel_x <= cur_sample.accel_x;
        accel_y <= cur_sample.accel_y;
        accel_z <= cur_sample.accel_z;
        sensor_fault <= cur_sample.sensor_fault;
        now_ms <= cur_sample.now_ms;
        in_valid <= 1'b1;
      end else if (!busy) begin
        in_valid <= 1'b0;
      end
      tx_wait <= w;
    end
  end

  // receiver ready pattern
  always @(posedge clk) begin : drive_ready
    int unsigned w;
    if (rst) begin
      out_ready <= 1'b0;
      rx_wait <= 0;
    end else begin
      w = rx_wait;
      if (out_valid && out_ready) w = rx_calm ? 0 : $urandom_range(0, MAX_WAIT);
      else if (w != 0) w = w - 1;
      rx_wait <= w;
      out_ready <= (w == 0) && (rx_hold == 0);
    end
  end

  // long output hold-off
  always @(posedge clk) begin
    if (rst) begin
      rx_hold <= 0;
      hold_done <= 1'b0;
    end else if (hold_armed && !hold_done) begin
      rx_hold <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
    end
  end

  // monitor
  always @(posedge clk) begin : check_results
    alarm_result_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = '{error_code, calibrating, siren_on, siren_trigger, alert_send};
      if (predicted_results.size() == 0) begin
        if (n_fail < 10) $display("%0t: unexpected result code=%h", $realtime, error_code);
        n_fail++;
      end else begin
        want = predicted_results.pop_front();
        n_checked++;
        if (want.calibrating) n_calib++;
        if (want.siren_trigger) n_trig++;
        if (want.alert_send) n_alert++;
        if (want.error_code[BIT_TILT]) n_tilt++;
        if (want.error_code[BIT_VIB]) n_vib++;
        if (want.error_code[BIT_FAULT]) n_fault++;
        if (got !== want) begin
          if (n_fail < 10) begin
            $display("%0t: mismatch exp code=%h cal=%b on=%b trig=%b alert=%b", $realtime,
                     want.error_code, want.calibrating, want.siren_on, want.siren_trigger,
                     want.alert_send);
            $display("            got code=%h cal=%b on=%b trig=%b alert=%b",
                     got.error_code, got.calibrating, got.siren_on, got.siren_trigger,
                     got.alert_send);
          end
          n_fail++;
        end
      end
    end
  end

  task automatic add_sample(input int gx, input int gy, input int gz, input int ax,
                            input int ay, input int az, input bit f, input logic [31:0] dt);
    sample_t s;
    t_now = t_now + dt;
    s.gyro_x = 16'(gx);
    s.gyro_y = 16'(gy);
    s.gyro_z = 16'(gz);
    s.accel_x = 16'(ax);
    s.accel_y = 16'(ay);
    s.accel_z = 16'(az);
    s.sensor_fault = f;
    s.now_ms = t_now;
    last_accel[0] = ax;
    last_accel[1] = ay;
    last_accel[2] = az;
    pending_samples.push_back(s);
  endtask

  function automatic int pick_extreme();
    case ($urandom_range(0, 3))
      0: return -32768;
      1: return 32767;
      2: return 0;
      default: return -1;
    endcase
  endfunction

  task automatic add_random_sample();
    int          g[3];
    int          a[3];
    int          r;
    logic [31:0] dt;
    for (int i = 0; i < 3; i++) begin
      r = $urandom_range(0, 99);
      if (r < 60) g[i] = int'($urandom_range(0, 3000)) - 1500;
      else if (r < 85) g[i] = int'($urandom_range(0, 65535)) - 32768;
      else g[i] = pick_extreme();
      r = $urandom_range(0, 99);
      if (r < 50) begin
        a[i] = last_accel[i] + int'($urandom_range(0, 120)) - 60;
        if (a[i] > 32767) a[i] = 32767;
        if (a[i] < -32768) a[i] = -32768;
      end else if (r < 80) begin
        a[i] = int'($urandom_range(0, 65535)) - 32768;
      end else begin
        a[i] = pick_extreme();
      end
    end
    r = $urandom_range(0, 99);
    if (r < 70) dt = $urandom_range(0, 12);
    else if (r < 90) dt = $urandom_range(13, 300);
    else if (r < 97) dt = $urandom_range(0, 70000);
    else dt = $urandom();
    add_sample(g[0], g[1], g[2], a[0], a[1], a[2], $urandom_range(0, 99) < 15, dt);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [31:0] val);
    logic [31:0] mask, data;
    mask = (idx == REG_VIB_TOL) ? 32'h0003_FFFF :
           (idx == REG_ALERT_GAP) ? 32'hFFFF_FFFF : 32'h0000_FFFF;
    // junk above the register width must be dropped
    data = (val & mask) | ($urandom() & ~mask);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_TILT_TOL:    sh_tilt = data[15:0];
      REG_VIB_TOL:     sh_vib = data[17:0];
      REG_CALIB_MS:    sh_calib = data[15:0];
      REG_SIREN_LEVEL: sh_siren_level = data[15:0];
      REG_ALERT_LEVEL: sh_alert_level = data[15:0];
      REG_SIREN_DUR:   sh_siren_dur = data[15:0];
      REG_SIREN_GAP:   sh_siren_gap = data[15:0];
      REG_ALERT_GAP:   sh_alert_gap = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic apply_setting(input logic [31:0] tilt, input logic [31:0] vib,
                               input logic [31:0] sl, input logic [31:0] al,
                               input logic [31:0] dur, input logic [31:0] gap,
                               input logic [31:0] agap);
    write_reg(REG_TILT_TOL, tilt);
    write_reg(REG_VIB_TOL, vib);
    write_reg(REG_SIREN_LEVEL, sl);
    write_reg(REG_ALERT_LEVEL, al);
    write_reg(REG_SIREN_DUR, dur);
    write_reg(REG_SIREN_GAP, gap);
    write_reg(REG_ALERT_GAP, agap);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_samples.size() != 0 || in_valid || out_valid ||
           predicted_results.size() != 0)
      @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_level();
    case ($urandom_range(0, 6))
      0: return 32'h0000;
      1: return 32'h2000;
      2: return 32'h2001;
      3: return 32'h4000;
      4: return 32'h8000;
      5: return 32'hE000;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    gyro_x = '0;
    gyro_y = '0;
    gyro_z = '0;
    accel_x = '0;
    accel_y = '0;
    accel_z = '0;
    sensor_fault = 1'b0;
    now_ms = '0;
    out_ready = 1'b0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    hold_armed = 1'b0;
    n_fail = 0;
    n_sent = 0;
    n_checked = 0;
    n_calib = 0;
    n_trig = 0;
    n_alert = 0;
    n_tilt = 0;
    n_vib = 0;
    n_fault = 0;
    sh_tilt = RST_TILT_TOL;
    sh_vib = RST_VIB_TOL;
    sh_calib = RST_CALIB_MS;
    sh_siren_level = RST_SIREN_LEVEL;
    sh_alert_level = RST_ALERT_LEVEL;
    sh_siren_dur = RST_SIREN_DUR;
    sh_siren_gap = RST_SIREN_GAP;
    sh_alert_gap = RST_ALERT_GAP;
    st_phase = ST_FIRST;
    st_calib_start = '0;
    st_siren_start = '0;
    st_alert_start = '0;
    st_accel_ref = 0;
    st_siren_on = 1'b0;
    for (int i = 0; i < 3; i++) begin
      st_min[i] = 0;
      st_max[i] = 0;
      last_accel[i] = 0;
    end
    t_now = 32'hFFFF_FF80;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // calibration at reset defaults, window wraps through zero
    add_sample(100, -100, 50, 1000, -2000, 3000, 1, 0);
    add_sample(-500, 400, -300, -32768, 32767, -32768, 1, 50);
    add_sample(500, -400, 300, 0, 0, 0, 0, 77);
    add_sample(0, 0, 0, 32767, -1, 0, 1, 1);
    add_sample(0, 0, 0, 5, 5, 5, 0, 71);
    wait_drained();
    write_reg(REG_CALIB_MS, 32'hFFFF);
    add_sample(0, 0, 0, 1, 2, 3, 0, 65335);
    wait_drained();
    // a zero window ends calibration on the next sample
    write_reg(REG_CALIB_MS, 32'h0);
    add_sample(0, 0, 0, 1000, -2000, 3000, 0, 1);
    add_sample(0, 0, 0, 1000, -2000, 3043, 0, 3);
    add_sample(0, 0, 0, 1000, -2000, 3085, 0, 4);
    add_sample(1483, 0, 0, 1000, -2000, 3085, 0, 7);
    add_sample(1484, 0, 0, 1000, -2000, 3085, 0, 1);
    add_sample(0, -1383, 0, 1000, -2000, 3085, 0, 2);
    add_sample(0, -1384, 0, 1000, -2000, 3085, 0, 3);
    add_sample(0, 0, 1284, 1000, -2000, 3085, 0, 1);
    add_sample(-32768, 32767, -32768, -32768, -32768, -32768, 1, 10);
    add_sample(0, 0, 0, 32767, 32767, 32767, 0, 11);
    add_sample(0, 0, 0, 32767, 32767, 32767, 1, 0);
    add_sample(-1483, 0, -1283, 32767, 32767, 32767, 0, 16);
    wait_drained();
    // zero tolerances, levels and gaps
    apply_setting(0, 0, 0, 0, 0, 0, 0);
    add_sample(0, 0, 0, 32767, 32767, 32767, 0, 0);
    add_sample(0, 0, 0, 32767, 32767, 32767, 0, 0);
    add_sample(0, 0, 0, 32767, 32767, 32767, 0, 1);
    add_sample(501, 0, 0, 32767, 32767, 32767, 0, 1);
    add_sample(0, 0, 0, 32767, 32767, 32766, 0, 1);
    wait_drained();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: apply_setting(983, 42, 1024, 32, 10, 5, 60000);
        1: apply_setting(0, 0, 0, 0, 0, 0, 0);
        2: apply_setting(32'hFFFF, 32'h3FFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF,
                         32'hFFFF_FFFF);
        default: apply_setting($urandom_range(0, 2000), $urandom_range(0, 300), pick_level(),
                               pick_level(), $urandom_range(0, 40), $urandom_range(0, 40),
                               $urandom_range(0, 200));
      endcase
      case (p)
        0: begin tx_calm = 1'b0; rx_calm = 1'b0; end
        1: begin tx_calm = 1'b1; rx_calm = 1'b1; end
        2: begin tx_calm = 1'b1; rx_calm = 1'b0; hold_armed = 1'b1; end
        3: begin tx_calm = 1'b0; rx_calm = 1'b1; end
        default: begin tx_calm = $urandom_range(0, 1); rx_calm = $urandom_range(0, 1); end
      endcase
      repeat (PHASE_ITEMS) add_random_sample();
      wait_drained();
    end

    if (predicted_results.size() != 0) n_fail++;
    $display("Checked %0d of %0d samples (%0d calibrating) over %0d register settings.",
             n_checked, n_sent, n_calib, RANDOM_PHASES + 3);
    $display("Flags seen: tilt %0d, vibration %0d, fault %0d; siren triggers %0d, alerts %0d.",
             n_tilt, n_vib, n_fault, n_trig, n_alert);
    if (n_fail == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/mta_pkg.sv
rtl/core/mta_axis_lane.sv
rtl/core/mta_alarm.sv
rtl/core/motion_tamper_alarm.sv
bench/motion_tamper_alarm_tb.sv
